// ===== design/assert_macros.svh =====
// Assertion helpers for the design folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/qnrf_pkg.sv =====
// ----------------------------------------------------------------------------
// qnrf_pkg
// Shared codes and reset values for the quartic Newton root finder.
// ----------------------------------------------------------------------------
`default_nettype none
package qnrf_pkg;
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_DERIV_ZERO = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  localparam logic [2:0] REG_C3 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C1 = 3'd2;
  localparam logic [2:0] REG_C0 = 3'd3;
  localparam logic [2:0] REG_EPS = 3'd4;
  localparam logic [2:0] REG_LIM = 3'd5;

  localparam logic [31:0] RST_C3 = 32'sd13421773;
  localparam logic [31:0] RST_C2 = -32'sd5033165;
  localparam logic [31:0] RST_C1 = -32'sd31876710;
  localparam logic [31:0] RST_C0 = 32'sd6710886;
  localparam logic [30:0] RST_EPS = 31'd1;
  localparam logic [7:0] RST_LIM = 8'd100;
endpackage
`default_nettype wire

// ===== design/quartic_newton_root_finder.sv =====
// ----------------------------------------------------------------------------
// quartic_newton_root_finder
// Newton-Raphson on a monic quartic, one shared multiplier and a radix-2
// divider under a small sequencer.
// ----------------------------------------------------------------------------
// channel   direction  signals
// command   in         start, busy, start_value
// result    out        done, root_value, status, iterations_used
// config    in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Steps: each iteration has one set-up state, 5 multiply steps, one derivative
// test, a restoring division of 2*DATA_WIDTH quotient bits (64 at defaults)
// and one update state. The iteration limit resets to 100, and the result
// passes through the done state, which raises done.
// Reset (rst, synchronous) restores the coefficient, tolerance and limit
// reset values and drops any work in flight. The result transfer
// lasts one cycle on done and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module quartic_newton_root_finder #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] start_value,
  output logic                              done,
  output logic signed [DATA_WIDTH-1:0]      root_value,
  output logic [1:0]                        status,
  output logic [7:0]                        iterations_used,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [4:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  localparam int W = DATA_WIDTH;
  localparam int QW = 2 * W + 1;
  localparam logic signed [W+1:0] VMAXE = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] VMINE = -VMAXE - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL, S_DTEST, S_DIV, S_UPD, S_DONE
  } state_t;

  state_t state;
  logic [31:0] c3, c2, c1, c0;
  logic [30:0] eps;
  logic [7:0] lim, n;
  logic signed [W-1:0] x, acc_p, acc_d, c3x3, c2x2;
  logic [2:0] mstep;
  // divider
  logic [2*W-1:0] dnum;
  logic [W:0] drem;
  logic [QW-1:0] dquo;
  logic [W-1:0] dmag;
  logic dneg;
  logic [$clog2(2*W+1)-1:0] dcnt;

  function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
    if (v > VMAXE) return {1'b0, {(W-1){1'b1}}};
    if (v < VMINE) return {1'b1, {(W-1){1'b0}}};
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return sat(W'(0) + {{2{a[W-1]}}, a} + {{2{b[W-1]}}, b});
  endfunction

  // shared multiplier: truncated toward zero then saturated
  logic signed [W-1:0] ma, mb, mres;
  logic [2*W-1:0] mprod;
  logic [W-1:0] mam, mbm;
  logic [2*W-1:0] msh;
  always_comb begin
    mam = ma[W-1] ? W'(-ma) : W'(ma);
    mbm = mb[W-1] ? W'(-mb) : W'(mb);
    mprod = {{W{1'b0}}, mam} * {{W{1'b0}}, mbm};
    msh = mprod >> FRAC_BITS;
    if (msh[2*W-1:W-1] != '0 && !(ma[W-1] ^ mb[W-1] && msh == (2*W)'(1) << (W-1)))
      mres = (ma[W-1] ^ mb[W-1]) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else
      mres = (ma[W-1] ^ mb[W-1]) ? W'(-msh[W-1:0]) : msh[W-1:0];
  end

  // operand selection per multiply step
  logic signed [W-1:0] sc3, sc2, sc1, sc0;
  assign sc3 = W'($signed(c3));
  assign sc2 = W'($signed(c2));
  assign sc1 = W'($signed(c1));
  assign sc0 = W'($signed(c0));
  always_comb begin
    mb = x;
    ma = (mstep < 3'd3) ? acc_p : acc_d;
  end

  logic signed [W-1:0] qsat, nx;
  logic signed [W:0] stepv;
  logic [W:0] stepm;
  logic [W-1:0] dpm;
  always_comb begin
    dpm = acc_d[W-1] ? W'(-acc_d) : W'(acc_d);
    if (dquo[QW-1:W-1] != '0 && !(dneg && dquo == QW'(1) << (W-1)))
      qsat = dneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else
      qsat = dneg ? W'(-dquo[W-1:0]) : dquo[W-1:0];
    nx = sat({{2{x[W-1]}}, x} - {{2{qsat[W-1]}}, qsat});
    stepv = {nx[W-1], nx} - {x[W-1], x};
    stepm = stepv[W] ? (W+1)'(-stepv) : stepv;
  end

  logic [W:0] rtry;
  assign rtry = {drem[W-1:0], dnum[2*W-1]} - {1'b0, dmag};

  assign busy = (state != S_IDLE);
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      qnrf_pkg::REG_C3: prdata = c3;
      qnrf_pkg::REG_C2: prdata = c2;
      qnrf_pkg::REG_C1: prdata = c1;
      qnrf_pkg::REG_C0: prdata = c0;
      qnrf_pkg::REG_EPS: prdata = {1'b0, eps};
      qnrf_pkg::REG_LIM: prdata = {24'd0, lim};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3 <= qnrf_pkg::RST_C3; c2 <= qnrf_pkg::RST_C2;
      c1 <= qnrf_pkg::RST_C1; c0 <= qnrf_pkg::RST_C0;
      eps <= qnrf_pkg::RST_EPS; lim <= qnrf_pkg::RST_LIM;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        qnrf_pkg::REG_C3: c3 <= pwdata;
        qnrf_pkg::REG_C2: c2 <= pwdata;
        qnrf_pkg::REG_C1: c1 <= pwdata;
        qnrf_pkg::REG_C0: c0 <= pwdata;
        qnrf_pkg::REG_EPS: eps <= pwdata[30:0];
        qnrf_pkg::REG_LIM: lim <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          x <= start_value;
          n <= '0;
          c3x3 <= sadd(sadd(sc3, sc3), sc3);
          c2x2 <= sadd(sc2, sc2);
          state <= S_PREP;
        end
        S_PREP: begin
          if (n == lim) begin
            root_value <= '0;
            status <= qnrf_pkg::ST_LIMIT;
            iterations_used <= lim;
            state <= S_DONE;
          end else begin
            n <= n + 8'd1;
            acc_p <= sadd(x, sc3);
            acc_d <= sadd(sadd(sadd(x, x), sadd(x, x)), c3x3);
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // p takes three products, p' two
          unique case (mstep)
            3'd0: acc_p <= sadd(mres, sc2);
            3'd1: acc_p <= sadd(mres, sc1);
            3'd2: acc_p <= sadd(mres, sc0);
            3'd3: acc_d <= sadd(mres, c2x2);
            default: acc_d <= sadd(mres, sc1);
          endcase
          mstep <= mstep + 3'd1;
          if (mstep == 3'd4) state <= S_DTEST;
        end
        S_DTEST: begin
          if (dpm == '0 || {1'b0, dpm} < (W+1)'(eps)) begin
            root_value <= '0;
            status <= qnrf_pkg::ST_DERIV_ZERO;
            iterations_used <= n;
            state <= S_DONE;
          end else begin
            dnum <= (2*W)'($unsigned(acc_p[W-1] ? -acc_p : acc_p)) << FRAC_BITS;
            dmag <= dpm;
            dneg <= acc_p[W-1] ^ acc_d[W-1];
            drem <= '0;
            dquo <= '0;
            dcnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit a cycle
          dnum <= dnum << 1;
          if (!rtry[W]) begin
            drem <= rtry;
            dquo <= {dquo[QW-2:0], 1'b1};
          end else begin
            drem <= {drem[W-1:0], dnum[2*W-1]};
            dquo <= {dquo[QW-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == ($bits(dcnt))'(2*W-1)) state <= S_UPD;
        end
        S_UPD: begin
          if (stepm < (W+1)'(eps)) begin
            root_value <= nx;
            status <= qnrf_pkg::ST_CONVERGED;
            iterations_used <= n;
            state <= S_DONE;
          end else begin
            x <= nx;
            state <= S_PREP;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_done_idle, clk, rst, done |-> state == S_IDLE, "done outside idle")
  `ASSERT_CLK(a_start_busy, clk, rst, (start && !busy) |=> busy, "start not taken")
  `ASSERT_CLK(a_iter_lim, clk, rst, done |-> iterations_used <= lim, "iterations over limit")
  `ASSERT_CLK(a_fail_zero, clk, rst, (done && status != qnrf_pkg::ST_CONVERGED) |-> root_value == '0,
              "failure root not zero")
endmodule
`default_nettype wire
